/* rtl/core/wamp_pkg.sv */
// ----------------------------------------------------------------------------
// wamp_pkg
// Types, constants, microcode ROM and helpers for the weekday alarm pulser.
// ----------------------------------------------------------------------------
package wamp_pkg;

    localparam int ALARM_ENTRIES = 8;
    localparam int ENTRY_W       = (ALARM_ENTRIES > 1) ? $clog2(ALARM_ENTRIES) : 1;

    // field widths
    localparam int CMD_W   = 3;
    localparam int IDX_W   = 3;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int MASK_W  = 7;
    localparam int DAY_W   = 3;
    localparam int MS_W    = 16;
    localparam int PULSE_W = 4;

    // APB
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_ALARM_ON     = 3'd0;
    localparam logic [2:0] REG_ALARM_OFF    = 3'd1;
    localparam logic [2:0] REG_ALARM_PULSES = 3'd2;
    localparam logic [2:0] REG_FIND_ON      = 3'd3;
    localparam logic [2:0] REG_FIND_OFF     = 3'd4;
    localparam logic [2:0] REG_FIND_PULSES  = 3'd5;

    // register reset values
    localparam logic [MS_W-1:0]    ALARM_ON_RST     = 16'd500;
    localparam logic [MS_W-1:0]    ALARM_OFF_RST    = 16'd200;
    localparam logic [PULSE_W-1:0] ALARM_PULSES_RST = 4'd5;
    localparam logic [MS_W-1:0]    FIND_ON_RST      = 16'd1000;
    localparam logic [MS_W-1:0]    FIND_OFF_RST     = 16'd200;
    localparam logic [PULSE_W-1:0] FIND_PULSES_RST  = 4'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 3'd0,
        CMD_CHECK = 3'd1,
        CMD_TICK  = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_FIND  = 3'd4
    } cmd_t;

    // sequencer steps (program addresses)
    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_WRITE   = 3'd1,
        ST_SCAN    = 3'd2,
        ST_CHK_END = 3'd3,
        ST_TICK    = 3'd4,
        ST_STOP    = 3'd5,
        ST_FIND    = 3'd6,
        ST_EMIT    = 3'd7
    } step_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_WRITE,
        OP_SCAN,
        OP_START_ALARM,
        OP_TICK,
        OP_STOP,
        OP_START_FIND,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        JMP_GOTO,
        JMP_DISPATCH,
        JMP_SCAN,
        JMP_OUT
    } jmp_t;

    typedef struct packed {
        op_t   op;
        jmp_t  jmp;
        step_t target;
    } ctl_t;

    function automatic ctl_t ucode(input step_t pc);
        ctl_t w;
        unique case (pc)
            ST_IDLE:    w = '{OP_NOP,         JMP_DISPATCH, ST_IDLE};
            ST_WRITE:   w = '{OP_WRITE,       JMP_GOTO,     ST_EMIT};
            ST_SCAN:    w = '{OP_SCAN,        JMP_SCAN,     ST_CHK_END};
            ST_CHK_END: w = '{OP_START_ALARM, JMP_GOTO,     ST_EMIT};
            ST_TICK:    w = '{OP_TICK,        JMP_GOTO,     ST_EMIT};
            ST_STOP:    w = '{OP_STOP,        JMP_GOTO,     ST_EMIT};
            ST_FIND:    w = '{OP_START_FIND,  JMP_GOTO,     ST_EMIT};
            ST_EMIT:    w = '{OP_EMIT,        JMP_OUT,      ST_IDLE};
        endcase
        return w;
    endfunction

    function automatic step_t dispatch(input logic [CMD_W-1:0] cmd);
        step_t s;
        unique case (cmd)
            CMD_WRITE: s = ST_WRITE;
            CMD_CHECK: s = ST_SCAN;
            CMD_TICK:  s = ST_TICK;
            CMD_STOP:  s = ST_STOP;
            CMD_FIND:  s = ST_FIND;
            default:   s = ST_EMIT;
        endcase
        return s;
    endfunction

    // weekday to mask bit: Sunday bit 0, Monday bit 6 .. Saturday bit 1
    function automatic logic [MASK_W-1:0] day_bit(input logic [DAY_W-1:0] wd);
        logic [MASK_W-1:0] b;
        unique case (wd)
            3'd0: b = 7'h01;
            3'd1: b = 7'h40;
            3'd2: b = 7'h20;
            3'd3: b = 7'h10;
            3'd4: b = 7'h08;
            3'd5: b = 7'h04;
            3'd6: b = 7'h02;
            3'd7: b = 7'h00;
        endcase
        return b;
    endfunction

    function automatic logic [MS_W-1:0] min1_ms(input logic [MS_W-1:0] v);
        return (v == '0) ? MS_W'(1) : v;
    endfunction

    function automatic logic [PULSE_W-1:0] min1_pulse(input logic [PULSE_W-1:0] v);
        return (v == '0) ? PULSE_W'(1) : v;
    endfunction

endpackage

/* rtl/core/wamp_if.sv */
// ----------------------------------------------------------------------------
// wamp_if
// Valid/ready channel interfaces for command beats and result beats.
// ----------------------------------------------------------------------------
interface wamp_in_if
    import wamp_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [IDX_W-1:0]    entry_index;
    logic                entry_enabled;
    logic [HOUR_W-1:0]   hour;
    logic [MIN_W-1:0]    minute;
    logic [MASK_W-1:0]   repeat_mask;
    logic [DAY_W-1:0]    weekday;

    modport source (
        output valid, command, entry_index, entry_enabled, hour, minute,
               repeat_mask, weekday,
        input  ready
    );
    modport sink (
        input  valid, command, entry_index, entry_enabled, hour, minute,
               repeat_mask, weekday,
        output ready
    );
endinterface

interface wamp_out_if
    import wamp_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                motor_on;
    logic                vibrate_start_pulse;
    logic                vibrate_stop_pulse;
    logic                alarm_running;
    logic                find_running;
    logic                alarm_fired;
    logic [2:0]          fired_index;
    logic                settings_changed;
    logic [PULSE_W-1:0]  remaining_pulses;

    modport source (
        output valid, motor_on, vibrate_start_pulse, vibrate_stop_pulse,
               alarm_running, find_running, alarm_fired, fired_index,
               settings_changed, remaining_pulses,
        input  ready
    );
    modport sink (
        input  valid, motor_on, vibrate_start_pulse, vibrate_stop_pulse,
               alarm_running, find_running, alarm_fired, fired_index,
               settings_changed, remaining_pulses,
        output ready
    );
endinterface

/* rtl/core/weekday_alarm_match_vibration_pulser.sv */
// ----------------------------------------------------------------------------
// weekday_alarm_match_vibration_pulser
// Alarm table with weekday mask match, driving a vibration pulse pattern.
// ----------------------------------------------------------------------------
//  Channel  Dir  Protocol     Beat contents
//  -------  ---  -----------  ---------------------------------------------
//  item     in   valid/ready  command + entry fields / current time, day
//  result   out  valid/ready  motor level, edges, run flags, fire status
//  APB      in   psel/penable six timing/count registers, 32-bit slots
//
//  One beat at a time. Write, tick, stop and find run dispatch, one op, emit;
//  unknown commands run dispatch, emit; a minute check runs dispatch, the
//  scan step (one entry per cycle, ending on a fire or the last entry), the
//  end-of-check step and emit. A new beat is taken while the previous result
//  still sits in the output register; the emit step waits only while that
//  register is full and not being drained.
//  Reset is asynchronous: entry enables, pattern state and registers return
//  to defaults at once, no clearing pass.
// ----------------------------------------------------------------------------
module weekday_alarm_match_vibration_pulser
    import wamp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    wamp_in_if.sink           item,
    wamp_out_if.source        result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam logic [ENTRY_W-1:0] LAST_ENTRY = ENTRY_W'(ALARM_ENTRIES - 1);

    // ---------------- configuration registers ----------------
    logic [MS_W-1:0]    alarm_on_reg, alarm_off_reg, find_on_reg, find_off_reg;
    logic [PULSE_W-1:0] alarm_pulses_reg, find_pulses_reg;
    logic               cfg_wr;
    logic [2:0]         cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_on_reg     <= ALARM_ON_RST;
            alarm_off_reg    <= ALARM_OFF_RST;
            alarm_pulses_reg <= ALARM_PULSES_RST;
            find_on_reg      <= FIND_ON_RST;
            find_off_reg     <= FIND_OFF_RST;
            find_pulses_reg  <= FIND_PULSES_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_ALARM_ON:     alarm_on_reg     <= pwdata[MS_W-1:0];
                REG_ALARM_OFF:    alarm_off_reg    <= pwdata[MS_W-1:0];
                REG_ALARM_PULSES: alarm_pulses_reg <= pwdata[PULSE_W-1:0];
                REG_FIND_ON:      find_on_reg      <= pwdata[MS_W-1:0];
                REG_FIND_OFF:     find_off_reg     <= pwdata[MS_W-1:0];
                REG_FIND_PULSES:  find_pulses_reg  <= pwdata[PULSE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_ALARM_ON:     prdata = APB_DW'(alarm_on_reg);
            REG_ALARM_OFF:    prdata = APB_DW'(alarm_off_reg);
            REG_ALARM_PULSES: prdata = APB_DW'(alarm_pulses_reg);
            REG_FIND_ON:      prdata = APB_DW'(find_on_reg);
            REG_FIND_OFF:     prdata = APB_DW'(find_off_reg);
            REG_FIND_PULSES:  prdata = APB_DW'(find_pulses_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    step_t pc_reg, pc_next;
    ctl_t  ctl;
    logic  in_take;
    logic  out_go;
    logic  scan_done;
    logic  res_valid_reg;

    assign ctl     = ucode(pc_reg);
    assign in_take = item.valid && item.ready;
    // emit may go once the output register is empty or being drained
    assign out_go  = (ctl.op == OP_EMIT) && (!res_valid_reg || result.ready);

    always_comb
    begin
        unique case (ctl.jmp)
            JMP_GOTO:     pc_next = ctl.target;
            JMP_DISPATCH: pc_next = in_take ? dispatch(item.command) : pc_reg;
            JMP_SCAN:     pc_next = scan_done ? ctl.target : pc_reg;
            JMP_OUT:      pc_next = out_go ? ctl.target : pc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= ST_IDLE;
        else
            pc_reg <= pc_next;
    end

    assign item.ready = (pc_reg == ST_IDLE);

    // ---------------- latched beat ----------------
    logic [IDX_W-1:0]  idx_reg;
    logic              en_reg;
    logic [HOUR_W-1:0] hour_reg;
    logic [MIN_W-1:0]  min_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [DAY_W-1:0]  day_reg;

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            idx_reg  <= item.entry_index;
            en_reg   <= item.entry_enabled;
            hour_reg <= item.hour;
            min_reg  <= item.minute;
            mask_reg <= item.repeat_mask;
            day_reg  <= item.weekday;
        end
    end

    // ---------------- alarm table ----------------
    logic                entry_on_reg   [ALARM_ENTRIES];
    logic [HOUR_W-1:0]   entry_hour_reg [ALARM_ENTRIES];
    logic [MIN_W-1:0]    entry_min_reg  [ALARM_ENTRIES];
    logic [MASK_W-1:0]   entry_mask_reg [ALARM_ENTRIES];
    logic [ENTRY_W-1:0]  wr_idx;
    logic                wr_ok;

    assign wr_idx = ENTRY_W'(idx_reg);
    assign wr_ok  = (ctl.op == OP_WRITE) && (int'(idx_reg) < ALARM_ENTRIES);

    // ---------------- scan datapath ----------------
    logic [ENTRY_W-1:0] scan_reg;
    logic               fired_reg;
    logic [2:0]         fidx_reg;
    logic               changed_reg;
    logic               was_on_reg;
    logic               vibrating_reg;
    logic               scan_match;
    logic               day_hit;
    logic               one_shot;
    logic               scan_fire;

    // entries are compared only when enabled, so unwritten fields never matter
    assign scan_match = entry_on_reg[scan_reg]
                     && (entry_hour_reg[scan_reg] == hour_reg)
                     && (entry_min_reg[scan_reg] == min_reg);
    assign day_hit    = (entry_mask_reg[scan_reg] & day_bit(day_reg)) != '0;
    assign one_shot   = entry_mask_reg[scan_reg] == '0;
    assign scan_fire  = (ctl.op == OP_SCAN) && scan_match && (day_hit || one_shot);
    assign scan_done  = scan_fire || (scan_reg == LAST_ENTRY);

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            entry_hour_reg[wr_idx] <= hour_reg;
            entry_min_reg[wr_idx]  <= min_reg;
            entry_mask_reg[wr_idx] <= mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALARM_ENTRIES; i++)
                entry_on_reg[i] <= 1'b0;
        end
        else if (wr_ok)
            entry_on_reg[wr_idx] <= en_reg;
        else if (scan_fire && !day_hit)
            entry_on_reg[scan_reg] <= 1'b0;    // one-shot entry retires
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg    <= '0;
            fired_reg   <= 1'b0;
            fidx_reg    <= '0;
            changed_reg <= 1'b0;
            was_on_reg  <= 1'b0;
        end
        else if (in_take)
        begin
            scan_reg    <= '0;
            fired_reg   <= 1'b0;
            fidx_reg    <= '0;
            changed_reg <= 1'b0;
            was_on_reg  <= vibrating_reg;
        end
        else if (ctl.op == OP_SCAN)
        begin
            if (scan_fire)
            begin
                fired_reg   <= 1'b1;
                fidx_reg    <= 3'(scan_reg);
                changed_reg <= !day_hit;
            end
            else if (!scan_done)
                scan_reg <= scan_reg + 1'b1;
        end
    end

    // ---------------- vibration pattern ----------------
    logic [PULSE_W-1:0] pulses_reg;
    logic [MS_W-1:0]    ms_reg;
    logic               alarm_act_reg;
    logic               find_act_reg;
    logic [PULSE_W-1:0] pulses_dec;
    logic [MS_W-1:0]    cur_on_ms;
    logic [MS_W-1:0]    cur_off_ms;

    assign pulses_dec = (pulses_reg != '0) ? pulses_reg - 1'b1 : '0;
    assign cur_on_ms  = min1_ms(alarm_act_reg ? alarm_on_reg : find_on_reg);
    assign cur_off_ms = min1_ms(alarm_act_reg ? alarm_off_reg : find_off_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vibrating_reg <= 1'b0;
            pulses_reg    <= '0;
            ms_reg        <= '0;
            alarm_act_reg <= 1'b0;
            find_act_reg  <= 1'b0;
        end
        else
        begin
            unique case (ctl.op)
                OP_START_ALARM:
                begin
                    if (fired_reg)
                    begin
                        alarm_act_reg <= 1'b1;
                        find_act_reg  <= 1'b0;
                        vibrating_reg <= 1'b1;
                        pulses_reg    <= min1_pulse(alarm_pulses_reg);
                        ms_reg        <= min1_ms(alarm_on_reg);
                    end
                end
                OP_START_FIND:
                begin
                    alarm_act_reg <= 1'b0;
                    find_act_reg  <= 1'b1;
                    vibrating_reg <= 1'b1;
                    pulses_reg    <= min1_pulse(find_pulses_reg);
                    ms_reg        <= min1_ms(find_on_reg);
                end
                OP_STOP:
                begin
                    alarm_act_reg <= 1'b0;
                    find_act_reg  <= 1'b0;
                    vibrating_reg <= 1'b0;
                    pulses_reg    <= '0;
                    ms_reg        <= '0;
                end
                OP_TICK:
                begin
                    if (alarm_act_reg || find_act_reg)
                    begin
                        if (ms_reg > MS_W'(1))
                            ms_reg <= ms_reg - 1'b1;
                        else if (vibrating_reg)
                        begin
                            vibrating_reg <= 1'b0;
                            pulses_reg    <= pulses_dec;
                            if (pulses_dec != '0)
                                ms_reg <= cur_off_ms;
                            else
                            begin
                                // last ON pulse ends the run
                                alarm_act_reg <= 1'b0;
                                find_act_reg  <= 1'b0;
                                ms_reg        <= '0;
                            end
                        end
                        else
                        begin
                            vibrating_reg <= 1'b1;
                            ms_reg        <= cur_on_ms;
                        end
                    end
                end
                OP_NOP, OP_WRITE, OP_SCAN, OP_EMIT: ;
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (out_go)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_go)
        begin
            result.motor_on            <= vibrating_reg;
            result.vibrate_start_pulse <= !was_on_reg && vibrating_reg;
            result.vibrate_stop_pulse  <= was_on_reg && !vibrating_reg;
            result.alarm_running       <= alarm_act_reg;
            result.find_running        <= find_act_reg;
            result.alarm_fired         <= fired_reg;
            result.fired_index         <= fidx_reg;
            result.settings_changed    <= changed_reg;
            result.remaining_pulses    <= pulses_reg;
        end
    end

    assign result.valid = res_valid_reg;

    // ---------------- checks ----------------
`ifndef SYNTH
    a_one_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        !(alarm_act_reg && find_act_reg))
        else $error("alarm and find patterns both active");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!alarm_act_reg && !find_act_reg) |->
            (!vibrating_reg && pulses_reg == '0 && ms_reg == '0))
        else $error("pattern state left over while idle");

    a_fire_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == ST_CHK_END && fired_reg) |=>
            (alarm_act_reg && vibrating_reg && pulses_reg != '0))
        else $error("matched alarm did not start the pattern");
`endif

endmodule
